>>> rtl/core/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
package u8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO      = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI      = 21'h00DFFF;
  localparam logic [CpW-1:0] SUB_RESET    = 21'h00FFFD;
  localparam logic [CpW-1:0] PV_E0_LEAD   = 21'h000000;
  localparam logic [CpW-1:0] PV_ED_LEAD   = 21'h00000D;
  localparam logic [CpW-1:0] PV_F0_LEAD   = 21'h000000;
  localparam logic [CpW-1:0] PV_F4_LEAD   = 21'h000004;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] CONT_A0  = 8'hA0;
  localparam logic [7:0] CONT_90  = 8'h90;

  localparam logic [16:0] MIN_2B = 17'h00080;
  localparam logic [16:0] MIN_3B = 17'h00800;
  localparam logic [16:0] MIN_4B = 17'h10000;

  // input action codes
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // one buffered input item
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  // results caused by one item: count 0..2, first result in cp0
  typedef struct packed {
    logic [1:0]     cnt;
    logic [CpW-1:0] cp0;
    logic [CpW-1:0] cp1;
  } res_t;

endpackage

>>> rtl/core/u8d_in_stage.sv
// Input register of the UTF-8 stream decoder.
`timescale 1ns / 1ps
module u8d_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  u8d_pkg::item_t in_item,
  output logic          s1_valid,
  output u8d_pkg::item_t s1_item,
  input  logic          s1_take
);

  logic           valid_r;
  u8d_pkg::item_t item_r;

  // free when empty or the held item moves on this cycle
  assign in_tready = !valid_r || s1_take;
  assign s1_valid  = valid_r;
  assign s1_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> rtl/core/u8d_decode.sv
// Decoder state and per-byte decode logic.
`timescale 1ns / 1ps
module u8d_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [u8d_pkg::CpW-1:0]   cfg_wr_data,
  input  logic                      step,
  input  u8d_pkg::item_t            item,
  output u8d_pkg::res_t             res
);

  logic [u8d_pkg::CpW-1:0] sub_r;
  logic [u8d_pkg::CpW-1:0] pv_r, pv_nxt;
  logic [1:0]              owed_r, owed_nxt;
  logic [16:0]             min_r, min_nxt;

  always_comb begin
    logic [7:0]              b;
    logic                    bad;
    logic [u8d_pkg::CpW-1:0] val;
    logic [u8d_pkg::CpW-1:0] e0, e1;
    logic [1:0]              n;
    b        = item.data_byte;
    bad      = 1'b0;
    val      = {pv_r[u8d_pkg::CpW-7:0], b[5:0]};
    e0       = sub_r;
    e1       = sub_r;
    n        = 2'd0;
    pv_nxt   = pv_r;
    owed_nxt = owed_r;
    min_nxt  = min_r;

    if (item.action == u8d_pkg::ACT_FLUSH) begin
      if (owed_r != 2'd0) begin
        owed_nxt = 2'd0;
        n        = 2'd1;
      end
    end else if (b[7:6] == 2'b10) begin
      bad = (owed_r == 2'd2 && pv_r == u8d_pkg::PV_E0_LEAD && b <  u8d_pkg::CONT_A0) ||
            (owed_r == 2'd2 && pv_r == u8d_pkg::PV_ED_LEAD && b >= u8d_pkg::CONT_A0) ||
            (owed_r == 2'd3 && pv_r == u8d_pkg::PV_F0_LEAD && b <  u8d_pkg::CONT_90) ||
            (owed_r == 2'd3 && pv_r == u8d_pkg::PV_F4_LEAD && b >= u8d_pkg::CONT_90);
      if (owed_r == 2'd0) begin
        n = 2'd1;                       // stray continuation
      end else if (bad) begin
        owed_nxt = 2'd0;
        n        = 2'd2;
      end else begin
        pv_nxt   = val;
        owed_nxt = owed_r - 2'd1;
        if (owed_r == 2'd1) begin
          n = 2'd1;
          if (!(val < {4'd0, min_r} || val > u8d_pkg::CP_MAX ||
                (val >= u8d_pkg::SURR_LO && val <= u8d_pkg::SURR_HI))) begin
            e0 = val;
          end
        end
      end
    end else begin
      // lead or ASCII byte: close any pending sequence first
      if (owed_r != 2'd0) begin
        owed_nxt = 2'd0;
        n        = 2'd1;
      end
      if (b[7] == 1'b0) begin
        if (n == 2'd0) begin
          e0 = {13'd0, b};
        end else begin
          e1 = {13'd0, b};
        end
        n = n + 2'd1;
      end else if (b inside {[u8d_pkg::LEAD2_LO:u8d_pkg::LEAD2_HI]}) begin
        pv_nxt   = {16'd0, b[4:0]};
        owed_nxt = 2'd1;
        min_nxt  = u8d_pkg::MIN_2B;
      end else if (b inside {[u8d_pkg::LEAD3_LO:u8d_pkg::LEAD3_HI]}) begin
        pv_nxt   = {17'd0, b[3:0]};
        owed_nxt = 2'd2;
        min_nxt  = u8d_pkg::MIN_3B;
      end else if (b inside {[u8d_pkg::LEAD4_LO:u8d_pkg::LEAD4_HI]}) begin
        pv_nxt   = {18'd0, b[2:0]};
        owed_nxt = 2'd3;
        min_nxt  = u8d_pkg::MIN_4B;
      end else begin
        n = n + 2'd1;                   // bad lead byte
      end
    end

    res.cnt = n;
    res.cp0 = e0;
    res.cp1 = e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r  <= u8d_pkg::SUB_RESET;
      pv_r   <= '0;
      owed_r <= 2'd0;
      min_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        sub_r <= cfg_wr_data;
      end
      if (step) begin
        pv_r   <= pv_nxt;
        owed_r <= owed_nxt;
        min_r  <= min_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a flush always leaves nothing pending
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.action == u8d_pkg::ACT_FLUSH |=> owed_r == 2'd0)
    else $error("flush left a sequence pending");
  // two results only when a sequence was pending or a bad continuation seen
  a_two_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.cnt == 2'd2 |-> owed_r != 2'd0)
    else $error("two results with nothing pending");
`endif

endmodule

>>> rtl/core/u8d_out_buf.sv
// Result pair register that hands results out one transfer at a time.
`timescale 1ns / 1ps
module u8d_out_buf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  u8d_pkg::res_t            res,
  output logic                     can_load,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [u8d_pkg::CpW-1:0]  out_cp,
  output logic                     out_tlast
);

  logic [1:0]              cnt_r;
  logic [u8d_pkg::CpW-1:0] cp0_r;
  logic [u8d_pkg::CpW-1:0] cp1_r;
  logic                    pop;

  assign out_tvalid = cnt_r != 2'd0;
  assign out_cp     = cp0_r;
  assign out_tlast  = cnt_r == 2'd1;
  assign pop        = out_tvalid && out_tready;
  assign can_load   = cnt_r == 2'd0 || (cnt_r == 2'd1 && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp0_r <= res.cp0;
      cp1_r <= res.cp1;
    end else if (pop) begin
      cp0_r <= cp1_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))
    else $error("pending result overwritten");
  a_pair_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && cnt_r == 2'd2 |=> cnt_r == 2'd1 && out_cp == $past(cp1_r))
    else $error("second result lost");
`endif

endmodule

>>> rtl/core/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder.
`timescale 1ns / 1ps
// Decodes a UTF-8 byte stream into 21-bit code points. Each input transfer
// carries one byte (in_tdata) and an action bit (in_tuser: 0 push the byte,
// 1 flush a pending sequence). Malformed input (stray continuation, bad lead,
// truncated, overlong, surrogate or above 0x10FFFF) yields the substitute code
// set through cfg_wr_en/cfg_wr_data (reset 0xFFFD). An input transfer causes
// zero, one or two result transfers; out_tlast marks the last one belonging to
// that input. An input register feeds the decode logic, which writes a
// two-entry result register, so a byte is accepted every cycle as long as it
// causes at most one result and the output side is ready; an input causing
// two results holds the decoder until the first of them is taken, the rate
// being set by the single output port draining one code point per cycle
// while out_tready is high. Write the substitute only while the block is
// idle.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,   // substitute_code
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tuser,      // [0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [20:0] code_point, [23:21] zero
  output logic        out_tlast      // last_of_run
);

  u8d_pkg::item_t          in_item;
  u8d_pkg::item_t          s1_item;
  u8d_pkg::res_t           res;
  logic                    s1_valid;
  logic                    can_load;
  logic                    step;
  logic [u8d_pkg::CpW-1:0] out_cp;

  assign in_item.action    = in_tuser;
  assign in_item.data_byte = in_tdata;

  // decode advances when a byte is held and the result register has room
  assign step = s1_valid && can_load;

  u8d_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (step)
  );

  u8d_decode u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (s1_item),
    .res         (res)
  );

  u8d_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_cp     (out_cp),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {3'b000, out_cp};

endmodule

>>> bench/u8d_scoreboard_pkg.sv
// Scoreboard class: decoder state mirror plus queue of expected code points.
`timescale 1ns / 1ps
package u8d_tb_pkg;
  import u8d_pkg::*;

  class cp_scoreboard;
    logic [CpW-1:0] subst;
    logic [CpW-1:0] partial;
    logic [1:0]     owed;
    logic [16:0]    min_cp;
    logic [CpW-1:0] exp_cp[$];
    bit             exp_last[$];
    int             errors;

    function new();
      subst   = SUB_RESET;
      partial = '0;
      owed    = '0;
      min_cp  = '0;
      errors  = 0;
    endfunction

    function void set_substitute(logic [CpW-1:0] code);
      subst = code;
    endfunction

    function bit idle();
      return exp_cp.size() == 0;
    endfunction

    // Advance the decoder mirror by one input transfer and queue its results.
    function void note_input(logic act, logic [7:0] b);
      logic [CpW-1:0] res[$];
      bit             bad_first;
      if (act == ACT_FLUSH) begin
        if (owed != 2'd0) begin
          owed = 2'd0;
          res.push_back(subst);
        end
      end else if (b[7:6] == 2'b10) begin
        if (owed == 2'd0) begin
          res.push_back(subst);
        end else begin
          bad_first = (owed == 2 && partial == PV_E0_LEAD && b < CONT_A0) ||
                      (owed == 2 && partial == PV_ED_LEAD && b >= CONT_A0) ||
                      (owed == 3 && partial == PV_F0_LEAD && b < CONT_90) ||
                      (owed == 3 && partial == PV_F4_LEAD && b >= CONT_90);
          if (bad_first) begin
            owed = 2'd0;
            res.push_back(subst);
            res.push_back(subst);
          end else begin
            partial = {partial[CpW-7:0], b[5:0]};
            owed    = owed - 2'd1;
            if (owed == 2'd0) begin
              if (partial < {4'b0, min_cp} || partial > CP_MAX ||
                  (partial >= SURR_LO && partial <= SURR_HI))
                res.push_back(subst);
              else
                res.push_back(partial);
            end
          end
        end
      end else begin
        if (owed != 2'd0) begin
          owed = 2'd0;
          res.push_back(subst);
        end
        if (b < 8'h80) begin
          res.push_back({13'b0, b});
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          partial = {16'b0, b[4:0]};
          owed    = 2'd1;
          min_cp  = MIN_2B;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          partial = {17'b0, b[3:0]};
          owed    = 2'd2;
          min_cp  = MIN_3B;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          partial = {18'b0, b[2:0]};
          owed    = 2'd3;
          min_cp  = MIN_4B;
        end else begin
          res.push_back(subst);
        end
      end
      foreach (res[i]) begin
        exp_cp.push_back(res[i]);
        exp_last.push_back(i == res.size() - 1);
      end
    endfunction

    function void check_result(logic [CpW-1:0] cp, logic last);
      logic [CpW-1:0] want_cp;
      bit             want_last;
      if (exp_cp.size() == 0) begin
        $display("%0t: unexpected result, code_point %h last %b", $time, cp, last);
        errors++;
        return;
      end
      want_cp   = exp_cp.pop_front();
      want_last = exp_last.pop_front();
      if (cp !== want_cp) begin
        $display("%0t: code_point expected %h, actual %h", $time, want_cp, cp);
        errors++;
      end
      if (last !== want_last) begin
        $display("%0t: last_of_run expected %b, actual %b", $time, want_last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> bench/tb_top.sv
// Top-level testbench for the UTF-8 stream decoder.
`timescale 1ns / 1ps
module tb_top;
  import u8d_pkg::*;
  import u8d_tb_pkg::*;

  localparam int WatchdogLimit = 2000;  // cycles with no transfer on either side
  localparam int HoldCycles    = 300;   // long receiver hold-off, fills the block
  localparam int SettleCycles  = 8;     // margin after the last expected result
  localparam int PhaseItems    = 120;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [20:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [20:0] code_point, [23:21] zero
  logic        out_tlast;  // last_of_run

  cp_scoreboard sb;

  // Shared pacing knobs. hold_left is set by the main flow and counted down
  // by the receiver process; the sender stops idling while it is nonzero.
  int hold_left = 0;
  bit send_gaps = 1'b1;
  bit rcv_gaps  = 1'b1;

  utf8_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, some short gaps, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offer one item and wait for its transfer. Entered and left at a
  // falling edge, so valid can stay high across back-to-back items.
  task automatic send_item(logic act, logic [7:0] b);
    int gap;
    gap = (hold_left > 0 || !send_gaps) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, b);
    @(negedge clk);
  endtask

  // Drop valid, let every expected result come out, then give the block a
  // few more cycles in case the last items were leads with no result.
  task automatic settle();
    in_tvalid = 1'b0;
    while (!sb.idle()) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_substitute(logic [20:0] code);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = code;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_substitute(code);
  endtask

  task automatic run_directed();
    send_item(ACT_PUSH, 8'h00);                           // lowest ASCII
    send_item(ACT_PUSH, 8'hC2); send_item(ACT_PUSH, 8'h80);  // smallest two-byte form
    send_item(ACT_PUSH, 8'hF4); send_item(ACT_PUSH, 8'h8F);  // largest scalar 10FFFF
    send_item(ACT_PUSH, 8'hBF); send_item(ACT_PUSH, 8'hBF);
    send_item(ACT_PUSH, 8'h80);                           // stray continuation
    send_item(ACT_PUSH, 8'hC0);                           // bad lead, nothing pending
    send_item(ACT_PUSH, 8'hE1); send_item(ACT_PUSH, 8'hFF);  // bad lead closes a pending one
    send_item(ACT_PUSH, 8'hE0); send_item(ACT_PUSH, 8'h80);  // overlong three-byte start
    send_item(ACT_PUSH, 8'hED); send_item(ACT_PUSH, 8'hA0);  // surrogate start
    send_item(ACT_PUSH, 8'hF0); send_item(ACT_PUSH, 8'h8F);  // overlong four-byte start
    send_item(ACT_PUSH, 8'hF4); send_item(ACT_PUSH, 8'h90);  // above 10FFFF
    send_item(ACT_PUSH, 8'hE1); send_item(ACT_PUSH, 8'h41);  // ASCII cuts a sequence short
    send_item(ACT_PUSH, 8'hC3); send_item(ACT_PUSH, 8'hE1);  // new lead cuts one short
    send_item(ACT_FLUSH, 8'hA5);                          // flush with a sequence pending
    send_item(ACT_FLUSH, 8'h5A);                          // flush with nothing pending
  endtask

  // Random traffic, mostly well-formed sequences with random scalar values,
  // the rest truncated or corrupted sequences, edge leads, flushes and noise.
  task automatic send_random(int count);
    logic [8:0]  chunk[$];
    logic [20:0] cp;
    logic [20:0] lo;
    logic [20:0] hi;
    logic [7:0]  lead;
    int          sent;
    int          r;
    int          len;
    int          cut;
    sent = 0;
    while (sent < count) begin
      chunk.delete();
      r = $urandom_range(0, 99);
      if (r < 25) begin
        chunk.push_back({ACT_PUSH, 8'($urandom_range(0, 127))});
      end else if (r < 65) begin
        len = $urandom_range(2, 4);
        case (len)
          2: begin
            lo = 21'h000080; hi = 21'h0007FF;
          end
          3: begin
            lo = 21'h000800; hi = 21'h00FFFF;
          end
          default: begin
            lo = 21'h010000; hi = 21'h10FFFF;
          end
        endcase
        r  = $urandom_range(0, 9);
        cp = (r == 0) ? lo : (r == 1) ? hi : 21'($urandom_range(lo, hi));
        // move surrogates out of the way, 9800..9FFF stays three bytes
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h004000;
        case (len)
          2: begin
            chunk.push_back({ACT_PUSH, 3'b110, cp[10:6]});
            chunk.push_back({ACT_PUSH, 2'b10, cp[5:0]});
          end
          3: begin
            chunk.push_back({ACT_PUSH, 4'b1110, cp[15:12]});
            chunk.push_back({ACT_PUSH, 2'b10, cp[11:6]});
            chunk.push_back({ACT_PUSH, 2'b10, cp[5:0]});
          end
          default: begin
            chunk.push_back({ACT_PUSH, 5'b11110, cp[20:18]});
            chunk.push_back({ACT_PUSH, 2'b10, cp[17:12]});
            chunk.push_back({ACT_PUSH, 2'b10, cp[11:6]});
            chunk.push_back({ACT_PUSH, 2'b10, cp[5:0]});
          end
        endcase
        r = $urandom_range(0, 99);
        if (r < 10) begin
          cut = $urandom_range(1, len - 1);
          repeat (cut) void'(chunk.pop_back());
        end else if (r < 18) begin
          chunk[$urandom_range(1, len - 1)] = {ACT_PUSH, 8'($urandom)};
        end
        if ($urandom_range(0, 9) == 0) chunk.push_back({ACT_FLUSH, 8'($urandom)});
      end else if (r < 75) begin
        // leads with a restricted first continuation, random continuations
        case ($urandom_range(0, 3))
          0:       lead = LEAD3_LO;
          1:       lead = 8'hED;
          2:       lead = LEAD4_LO;
          default: lead = LEAD4_HI;
        endcase
        chunk.push_back({ACT_PUSH, lead});
        repeat (lead[4] ? 3 : 2) chunk.push_back({ACT_PUSH, 2'b10, 6'($urandom)});
      end else if (r < 85) begin
        chunk.push_back({ACT_FLUSH, 8'($urandom)});
      end else begin
        chunk.push_back({ACT_PUSH, 8'($urandom)});
      end
      foreach (chunk[i]) send_item(chunk[i][8], chunk[i][7:0]);
      sent += chunk.size();
    end
  endtask

  // Receiver: ready changes at the falling edge. Runs of random stalls,
  // stretches of steady ready, and the long hold-off when requested.
  initial begin
    int stall_run;
    int mode_cnt;
    stall_run  = 0;
    mode_cnt   = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      mode_cnt++;
      if (mode_cnt == 100) begin
        mode_cnt  = 0;
        send_gaps = ($urandom_range(0, 3) != 0);
        rcv_gaps  = ($urandom_range(0, 3) != 0);
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_run > 0) begin
        out_tready = 1'b0;
        stall_run--;
      end else begin
        out_tready = 1'b1;
        if (rcv_gaps) stall_run = pick_gap();
      end
    end
  end

  // Result transfers are checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[20:0], out_tlast);
  end

  // Watchdog: too long without a transfer on either side ends the run.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WatchdogLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    logic [20:0] sub_plan [5];
    sb          = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = ACT_PUSH;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // reset substitute first, directed cases
    run_directed();

    // one phase per substitute setting: zero, top scalar, all ones (out of
    // range, passed through as is), a random one, back to the reset value
    sub_plan    = '{21'h000000, 21'h10FFFF, 21'h1FFFFF, 21'h000000, SUB_RESET};
    sub_plan[3] = 21'($urandom_range(0, 21'h1FFFFF));
    foreach (sub_plan[i]) begin
      settle();
      write_substitute(sub_plan[i]);
      if (i == 1) hold_left = HoldCycles;
      send_random(PhaseItems);
    end
    settle();

    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
